/* design/css_pkg.sv */
// Package for the clash severity statistics block.
// Holds action codes, fixed-point constants, divider status type and helpers.
// No dependencies.
package css_pkg;

    localparam logic [1:0] ACT_PAIR = 2'd0;
    localparam logic [1:0] ACT_HIST = 2'd1;
    localparam logic [1:0] ACT_LIST = 2'd2;

    localparam logic [15:0] SCORE_MAX = 16'd40960;
    localparam logic [27:0] ONE_Q12   = 28'd4096;

    localparam int DIV_QW = 28;
    localparam int DIV_DW = 32;

    localparam logic       REG_BPU = 1'b0;
    localparam logic       REG_TOP = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } css_div_status_t;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

/* design/clash_severity_statistics.sv */
// Top level of the clash severity statistics block.
// Depends on css_pkg and css_div.
//
// After reset the block clears every histogram bin and accepts no item meanwhile. A scored
// atom pair waits on the 28-step iterative divider that forms ideal/actual; bonded or
// zero-distance pairs skip the divider. A pair marked last adds the histogram
// read-modify-write and the output load; a positive score adds the running-average divide
// and the worst-list insertion, which shifts each smaller entry down one place at a time.
// Results wait in an output register, so a new item is taken while one is pending; the
// next result holds the block until the pending one leaves.
module clash_severity_statistics #(
    parameter int HIST_BINS = 128,
    parameter int TOP_DEPTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ideal_distance[15:0], actual_distance[31:16], bonded[32], structure_id[48:33],
    // read_index[55:49]
    input  logic [55:0]  s_tdata,
    // action[1:0]
    input  logic [1:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // structure_score[15:0], inserted[16], worst_score[32:17], average_score[48:33],
    // clashing_structures[80:49], clashing_pairs[112:81], read_count[144:113],
    // read_id[160:145], read_score[176:161], read_valid[177], zero[183:178]
    output logic [183:0] m_tdata,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [4:0]   cfg_data
);
    import css_pkg::*;

    localparam int HA = $clog2(HIST_BINS);
    localparam int LA = (TOP_DEPTH > 1) ? $clog2(TOP_DEPTH) : 1;
    localparam int FW = $clog2(TOP_DEPTH + 1);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DIVP   = 4'd2;
    localparam logic [3:0] S_PAIR   = 4'd3;
    localparam logic [3:0] S_FIN    = 4'd4;
    localparam logic [3:0] S_HUPD   = 4'd5;
    localparam logic [3:0] S_AVGW   = 4'd6;
    localparam logic [3:0] S_LSTART = 4'd7;
    localparam logic [3:0] S_LCHK   = 4'd8;
    localparam logic [3:0] S_LSTEP  = 4'd9;
    localparam logic [3:0] S_LCMP   = 4'd10;
    localparam logic [3:0] S_RDH    = 4'd11;
    localparam logic [3:0] S_RDL    = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    logic [3:0]    state_reg, state_next;
    logic [HA-1:0] clr_reg, clr_next;
    logic          last_reg, last_next;
    logic [15:0]   id_reg, id_next;
    logic [15:0]   ps_reg, ps_next;
    logic [15:0]   cmax_reg, cmax_next;
    logic [15:0]   ss_reg, ss_next;
    logic [HA-1:0] bin_reg, bin_next;
    logic [15:0]   worst_reg, worst_next;
    logic [15:0]   avg_reg, avg_next;
    logic          neg_reg, neg_next;
    logic [31:0]   sc_reg, sc_next;
    logic [31:0]   pc_reg, pc_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [LA-1:0] i_reg, i_next;
    logic [3:0]    bpu_reg, bpu_next;
    logic [4:0]    top_reg, top_next;
    logic          ins_reg, ins_next;
    logic [31:0]   rc_reg, rc_next;
    logic [15:0]   rid_reg, rid_next;
    logic [15:0]   rsc_reg, rsc_next;
    logic          rv_reg, rv_next;
    logic          ov_reg, ov_next;
    logic [183:0]  od_reg, od_next;

    // Histogram and worst-list memories
    logic [31:0]   hist_mem [HIST_BINS];
    logic [31:0]   list_mem [TOP_DEPTH];
    logic          hist_we, list_we;
    logic [HA-1:0] hist_wa, hist_ra;
    logic [LA-1:0] list_wa, list_ra;
    logic [31:0]   hist_wd, list_wd, hist_rd, list_rd;

    // Divider
    logic                  div_start;
    logic [DIV_QW-1:0]     div_dividend, div_q;
    logic [DIV_DW-1:0]     div_divisor;
    css_div_status_t       div_st;

    css_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .status   (div_st)
    );

    // Decoded input fields
    logic [15:0] in_ideal, in_actual, in_id;
    logic        in_bonded;
    logic [6:0]  in_idx;
    logic [10:0] idx_h;
    logic [8:0]  idx_l;
    assign in_ideal  = s_tdata[15:0];
    assign in_actual = s_tdata[31:16];
    assign in_bonded = s_tdata[32];
    assign in_id     = s_tdata[48:33];
    assign in_idx    = s_tdata[55:49];
    assign idx_h     = {4'd0, in_idx};
    assign idx_l     = {2'd0, in_idx};

    // Helpers
    logic [8:0]    lim9;
    logic [FW-1:0] lim;
    logic [15:0]   bmax, absd;
    logic [19:0]   bsum;
    logic [10:0]   bin11;
    logic [16:0]   diff;
    logic [27:0]   rdiff;
    logic [31:0]   new_word;
    logic [3:0]    bpu_eff;

    assign lim9     = ({4'd0, top_reg} < 9'(TOP_DEPTH)) ? {4'd0, top_reg} : 9'(TOP_DEPTH);
    assign lim      = lim9[FW-1:0];
    assign bmax     = (ps_reg > cmax_reg) ? ps_reg : cmax_reg;
    assign bpu_eff  = (bpu_reg == 4'd0) ? 4'd1 : bpu_reg;
    assign bsum     = 20'(cmax_reg * bpu_eff) + 20'd2048;
    assign bin11    = ({3'd0, bsum[19:12]} > 11'(HIST_BINS - 1)) ?
                      11'(HIST_BINS - 1) : {3'd0, bsum[19:12]};
    assign diff     = {1'b0, ss_reg} - {1'b0, avg_reg};
    assign absd     = diff[16] ? 16'(-diff) : diff[15:0];
    assign rdiff    = div_q - ONE_Q12;
    assign new_word = {id_reg, ss_reg};

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        last_next  = last_reg;
        id_next    = id_reg;
        ps_next    = ps_reg;
        cmax_next  = cmax_reg;
        ss_next    = ss_reg;
        bin_next   = bin_reg;
        worst_next = worst_reg;
        avg_next   = avg_reg;
        neg_next   = neg_reg;
        sc_next    = sc_reg;
        pc_next    = pc_reg;
        fill_next  = fill_reg;
        i_next     = i_reg;
        bpu_next   = bpu_reg;
        top_next   = top_reg;
        ins_next   = ins_reg;
        rc_next    = rc_reg;
        rid_next   = rid_reg;
        rsc_next   = rsc_reg;
        rv_next    = rv_reg;
        ov_next    = ov_reg & ~m_tready;
        od_next    = od_reg;
        hist_we    = 1'b0;
        hist_wa    = bin_reg;
        hist_wd    = sat_inc32(hist_rd);
        hist_ra    = idx_h[HA-1:0];
        list_we    = 1'b0;
        list_wa    = i_reg;
        list_wd    = new_word;
        list_ra    = idx_l[LA-1:0];
        div_start    = 1'b0;
        div_dividend = {in_ideal, 12'd0};
        div_divisor  = {16'd0, in_actual};

        // Apply register writes; shrink the list with the limit
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BPU: bpu_next = cfg_data[3:0];
                REG_TOP:
                begin
                    top_next = cfg_data;
                    if ({4'd0, cfg_data} < 9'(TOP_DEPTH))
                    begin
                        if ({4'd0, fill_reg} > {4'd0, cfg_data})
                            fill_next = FW'(cfg_data);
                    end
                end
                default: ;
            endcase
        end

        case (state_reg)
            S_CLEAR:
            begin
                hist_we = 1'b1;
                hist_wa = clr_reg;
                hist_wd = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == HA'(HIST_BINS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    last_next = s_tlast;
                    id_next   = in_id;
                    ins_next  = 1'b0;
                    rc_next   = '0;
                    rid_next  = '0;
                    rsc_next  = '0;
                    rv_next   = 1'b0;
                    ss_next   = '0;
                    case (s_tuser)
                        ACT_PAIR:
                        begin
                            if (in_bonded)
                            begin
                                ps_next    = '0;
                                state_next = S_PAIR;
                            end
                            else if (in_actual == 16'd0)
                            begin
                                ps_next    = SCORE_MAX;
                                state_next = S_PAIR;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIVP;
                            end
                        end
                        ACT_HIST:
                        begin
                            rv_next    = (idx_h < 11'(HIST_BINS));
                            state_next = S_RDH;
                        end
                        ACT_LIST:
                        begin
                            rv_next    = (idx_l < {{(9-FW){1'b0}}, fill_reg}) &&
                                         (idx_l < 9'(TOP_DEPTH));
                            state_next = S_RDL;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIVP:
            begin
                if (div_st.done)
                begin
                    if (div_q <= ONE_Q12)
                        ps_next = '0;
                    else if (rdiff > {12'd0, SCORE_MAX})
                        ps_next = SCORE_MAX;
                    else
                        ps_next = rdiff[15:0];
                    state_next = S_PAIR;
                end
            end
            S_PAIR:
            begin
                if (ps_reg != 16'd0)
                    pc_next = sat_inc32(pc_reg);
                cmax_next  = bmax;
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                // Read the bin while the score closes out
                hist_ra    = bin11[HA-1:0];
                bin_next   = bin11[HA-1:0];
                ss_next    = cmax_reg;
                cmax_next  = '0;
                state_next = S_HUPD;
            end
            S_HUPD:
            begin
                hist_we = 1'b1;
                if (ss_reg != 16'd0)
                begin
                    sc_next      = sat_inc32(sc_reg);
                    neg_next     = diff[16];
                    div_start    = 1'b1;
                    div_dividend = {12'd0, absd};
                    div_divisor  = sat_inc32(sc_reg);
                    state_next   = S_AVGW;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_AVGW:
            begin
                if (div_st.done)
                begin
                    avg_next = neg_reg ? avg_reg - div_q[15:0] : avg_reg + div_q[15:0];
                    if (ss_reg > worst_reg)
                        worst_next = ss_reg;
                    state_next = S_LSTART;
                end
            end
            S_LSTART:
            begin
                list_ra = LA'(fill_reg - 1'b1);
                if (lim == '0)
                    state_next = S_OUT;
                else if (fill_reg >= lim)
                    state_next = S_LCHK;
                else
                begin
                    i_next     = LA'(fill_reg);
                    state_next = S_LSTEP;
                end
            end
            S_LCHK:
            begin
                if (ss_reg <= list_rd[15:0])
                    state_next = S_OUT;
                else
                begin
                    i_next     = LA'(lim - 1'b1);
                    state_next = S_LSTEP;
                end
            end
            S_LSTEP:
            begin
                list_ra = i_reg - 1'b1;
                if (i_reg == '0)
                begin
                    list_we  = 1'b1;
                    ins_next = 1'b1;
                    if (fill_reg < lim)
                        fill_next = fill_reg + 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_LCMP;
                end
            end
            S_LCMP:
            begin
                list_we = 1'b1;
                if (list_rd[15:0] < ss_reg)
                begin
                    // Shift the smaller entry down one place
                    list_wd    = list_rd;
                    i_next     = i_reg - 1'b1;
                    state_next = S_LSTEP;
                end
                else
                begin
                    ins_next = 1'b1;
                    if (fill_reg < lim)
                        fill_next = fill_reg + 1'b1;
                    state_next = S_OUT;
                end
            end
            S_RDH:
            begin
                if (rv_reg)
                    rc_next = hist_rd;
                state_next = S_OUT;
            end
            S_RDL:
            begin
                if (rv_reg)
                begin
                    rid_next = list_rd[31:16];
                    rsc_next = list_rd[15:0];
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next = 1'b1;
                    od_next = {6'd0, rv_reg, rsc_reg, rid_reg, rc_reg, pc_reg, sc_reg,
                               avg_reg, worst_reg, ins_reg, ss_reg};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            cmax_reg  <= '0;
            worst_reg <= '0;
            avg_reg   <= '0;
            sc_reg    <= '0;
            pc_reg    <= '0;
            fill_reg  <= '0;
            bpu_reg   <= 4'd10;
            top_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cmax_reg  <= cmax_next;
            worst_reg <= worst_next;
            avg_reg   <= avg_next;
            sc_reg    <= sc_next;
            pc_reg    <= pc_next;
            fill_reg  <= fill_next;
            bpu_reg   <= bpu_next;
            top_reg   <= top_next;
            ov_reg    <= ov_next;
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        id_reg   <= id_next;
        ps_reg   <= ps_next;
        ss_reg   <= ss_next;
        bin_reg  <= bin_next;
        neg_reg  <= neg_next;
        i_reg    <= i_next;
        ins_reg  <= ins_next;
        rc_reg   <= rc_next;
        rid_reg  <= rid_next;
        rsc_reg  <= rsc_next;
        rv_reg   <= rv_next;
        od_reg   <= od_next;
    end

    // Memory ports, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_wa] <= hist_wd;
        hist_rd <= hist_mem[hist_ra];
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
            list_mem[list_wa] <= list_wd;
        list_rd <= list_mem[list_ra];
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(TOP_DEPTH))
        else $error("list fill beyond depth");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == S_DIVP || state_reg == S_AVGW))
        else $error("divider finished outside a wait state");

    a_hist_we: assert property (@(posedge clk) disable iff (!rst_n)
        hist_we |-> (state_reg == S_CLEAR || state_reg == S_HUPD))
        else $error("histogram written outside clear or update");

    a_ready_div: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !div_st.busy)
        else $error("item accepted while divider busy");

endmodule

/* design/css_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on css_pkg for widths and the status struct.
module css_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [css_pkg::DIV_QW-1:0]       dividend,
    input  logic [css_pkg::DIV_DW-1:0]       divisor,
    output logic [css_pkg::DIV_QW-1:0]       quotient,
    output css_pkg::css_div_status_t         status
);
    import css_pkg::*;

    logic [DIV_DW:0]   rem_reg, rem_next;
    logic [DIV_QW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] dsr_reg, dsr_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_DW:0]   trial;
    logic              fits;

    // Shift in one dividend bit and try a subtract
    always_comb
    begin
        trial     = {rem_reg[DIV_DW-1:0], quo_reg[DIV_QW-1]};
        fits      = (trial >= {1'b0, dsr_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = 5'(DIV_QW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial - {1'b0, dsr_reg} : trial;
            quo_next = {quo_reg[DIV_QW-2:0], fits};
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
